// File: sv/fpgt_pkg.sv
// shared types, rule tables and defuzzification constants for the fuzzy gain tuner
package fpgt_pkg;

    localparam int SampleWidthDef = 16;
    localparam int GradeWidth     = 14;
    localparam int LabelWidth     = 3;
    localparam int NumLabels      = 7;
    localparam int NumWidth       = 18;
    localparam int OneGrade       = 8192;
    localparam int Unit           = 4096;

    typedef logic [GradeWidth-1:0]  t_grade;
    typedef t_grade [NumLabels-1:0] t_grades;
    typedef logic [LabelWidth-1:0]  t_label;

    typedef struct packed {
        logic [15:0] delta_kd;
        logic [15:0] delta_ki;
        logic [15:0] delta_kp;
    } t_result;

    typedef logic [2:0] t_tab [0:6][0:6];

    localparam t_tab TabKp = '{
        '{3'd6,3'd6,3'd5,3'd5,3'd4,3'd4,3'd3},
        '{3'd6,3'd6,3'd5,3'd5,3'd4,3'd3,3'd3},
        '{3'd5,3'd5,3'd4,3'd4,3'd3,3'd2,3'd1},
        '{3'd5,3'd4,3'd4,3'd3,3'd2,3'd1,3'd1},
        '{3'd4,3'd4,3'd3,3'd2,3'd2,3'd1,3'd1},
        '{3'd3,3'd3,3'd2,3'd1,3'd1,3'd1,3'd0},
        '{3'd3,3'd2,3'd2,3'd1,3'd1,3'd0,3'd0}};

    localparam t_tab TabKi = '{
        '{3'd6,3'd4,3'd4,3'd3,3'd4,3'd5,3'd5},
        '{3'd6,3'd4,3'd4,3'd3,3'd4,3'd5,3'd5},
        '{3'd6,3'd5,3'd5,3'd3,3'd2,3'd4,3'd5},
        '{3'd6,3'd5,3'd5,3'd3,3'd2,3'd4,3'd5},
        '{3'd6,3'd6,3'd5,3'd3,3'd2,3'd2,3'd5},
        '{3'd6,3'd6,3'd6,3'd3,3'd1,3'd2,3'd4},
        '{3'd6,3'd6,3'd6,3'd3,3'd1,3'd2,3'd4}};

    localparam t_tab TabKd = '{
        '{3'd4,3'd4,3'd3,3'd3,3'd3,3'd6,3'd6},
        '{3'd2,3'd2,3'd2,3'd2,3'd3,3'd2,3'd5},
        '{3'd0,3'd0,3'd1,3'd2,3'd3,3'd4,3'd5},
        '{3'd0,3'd1,3'd1,3'd2,3'd3,3'd4,3'd5},
        '{3'd0,3'd1,3'd1,3'd2,3'd3,3'd4,3'd4},
        '{3'd1,3'd2,3'd2,3'd2,3'd3,3'd4,3'd4},
        '{3'd4,3'd3,3'd3,3'd3,3'd3,3'd6,3'd6}};

    // n = 8192*p + q*g, signed, fits 18 bits
    function automatic logic signed [NumWidth-1:0] line_num(t_label lbl, t_grade g);
        logic signed [NumWidth-1:0] gs;
        logic signed [NumWidth-1:0] n;
        gs = NumWidth'(signed'({1'b0, g}));
        case (lbl)
            3'd0:    n = -NumWidth'(signed'(17'sd16384)) - (gs <<< 2);
            3'd1:    n = -NumWidth'(signed'(17'sd24576)) - gs;
            3'd2:    n = -NumWidth'(signed'(17'sd16384));
            3'd3:    n = '0;
            3'd4:    n = NumWidth'(signed'(17'sd16384));
            3'd5:    n = NumWidth'(signed'(17'sd24576)) + gs;
            3'd6:    n = NumWidth'(signed'(17'sd16384)) + (gs <<< 2);
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

// File: sv/fpgt_fuzzify.sv
// fuzzifier: saturates one sample and forms its seven membership grades
module fpgt_fuzzify
    import fpgt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SampleWidthDef
) (
    input  logic [SAMPLE_WIDTH-1:0] i_x,
    output t_grades                 o_g
);

    logic signed [16:0] x;

    always_comb begin
        if (SAMPLE_WIDTH > 16) begin
            if ($signed(i_x) > $signed(SAMPLE_WIDTH'(32767)))
                x = 17'sd32767;
            else if ($signed(i_x) < -$signed(SAMPLE_WIDTH'(32768)))
                x = -17'sd32768;
            else
                x = 17'(signed'(i_x));
        end else begin
            x = 17'(signed'(i_x));
        end
    end

    // grade = 2*(x - a)/(b - a); spans are 1, 2 or 3 units
    function automatic t_grade rise(logic signed [16:0] xv, int a, int span);
        logic [19:0] d;
        logic [19:0] q;
        d = 20'(xv - 17'(a * Unit)) << 1;
        if (span == 1)      q = d;
        else if (span == 2) q = d >> 1;
        else                q = 20'((d * 20'd43691) >> 17);
        return GradeWidth'(q);
    endfunction

    function automatic t_grade fall(logic signed [16:0] xv, int c, int span);
        logic [19:0] d;
        logic [19:0] q;
        d = 20'(17'(c * Unit) - xv) << 1;
        if (span == 1)      q = d;
        else if (span == 2) q = d >> 1;
        else                q = 20'((d * 20'd43691) >> 17);
        return GradeWidth'(q);
    endfunction

    function automatic t_grade tri_grade(logic signed [16:0] xv, int a, int b, int c);
        if (xv <= 17'(a * Unit))      return '0;
        else if (xv <= 17'(b * Unit)) return rise(xv, a, b - a);
        else if (xv <= 17'(c * Unit)) return fall(xv, c, c - b);
        return '0;
    endfunction

    always_comb begin
        if (x <= -17'sd12288)     o_g[0] = GradeWidth'(OneGrade);
        else if (x <= -17'sd4096) o_g[0] = fall(x, -1, 2);
        else                      o_g[0] = '0;
        o_g[1] = tri_grade(x, -3, -2, 0);
        o_g[2] = tri_grade(x, -3, -1, 1);
        o_g[3] = tri_grade(x, -2, 0, 2);
        o_g[4] = tri_grade(x, -1, 1, 3);
        o_g[5] = tri_grade(x, 0, 2, 3);
        if (x <= 17'sd4096)       o_g[6] = '0;
        else if (x <= 17'sd12288) o_g[6] = rise(x, 1, 2);
        else                      o_g[6] = GradeWidth'(OneGrade);
    end

endmodule

// File: sv/fpgt_defuzz.sv
// defuzzifier: rounds n*k/d for the three gains
module fpgt_defuzz
    import fpgt_pkg::*;
(
    input  logic signed [NumWidth-1:0] i_nkp,
    input  logic signed [NumWidth-1:0] i_nki,
    input  logic signed [NumWidth-1:0] i_nkd,
    output t_result                    o_res
);

    // floor((2nk + d)/(2d)), d = 25: reciprocal estimate on shifted nonnegative value
    function automatic logic [15:0] div25(logic signed [NumWidth+4:0] t);
        logic [NumWidth+4:0] u;
        logic [NumWidth+4:0] q;
        logic [NumWidth+4:0] r;
        u = t + (NumWidth+5)'(50 * 65536);
        q = (NumWidth+5)'(({22'd0, u} * 45'd335544) >> 24);
        r = u - q * (NumWidth+5)'(50);
        if (r >= (NumWidth+5)'(50)) q = q + 1'b1;
        return 16'(q - (NumWidth+5)'(65536));
    endfunction

    logic signed [NumWidth+4:0] tki;
    logic signed [NumWidth+4:0] tkd;
    logic signed [NumWidth-1:0] tkp;

    always_comb begin
        tkp = i_nkp + NumWidth'(2);
        tki = ((NumWidth+5)'(i_nki) <<< 4) + (NumWidth+5)'(25);
        tkd = (NumWidth+5)'(i_nkd) * (NumWidth+5)'(6) + (NumWidth+5)'(25);
        o_res.delta_kp = 16'(tkp >>> 2);
        o_res.delta_ki = div25(tki);
        o_res.delta_kd = div25(tkd);
    end

endmodule

// File: sv/fuzzy_pid_gain_tuner_unit.sv
// fuzzy self-tuning pid gain corrections, top level
// One result per item; an item may enter every cycle. Five register stages: saturation and
// fuzzification, 49 rule minima, winning cell of each row, winning row with table lookup, then
// line evaluation and rounding. A stalled output holds every stage.
module fuzzy_pid_gain_tuner_unit
    import fpgt_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SampleWidthDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [2*SAMPLE_WIDTH-1:0] s_axis_tdata,  // error_value, error_change
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [47:0]               m_axis_tdata   // delta_kp, delta_ki, delta_kd
);

    typedef struct packed {
        t_grade     val;
        logic [2:0] idx;
    } t_pick;

    logic [4:0] r_v;
    logic       adv;
    assign adv = !r_v[4] || m_axis_tready;
    assign s_axis_tready = adv;

    t_grades ge, gc;
    t_grades r_ge, r_gc;
    t_grades r_s [0:6];
    t_pick   r_row [0:6];
    t_pick   n_row [0:6];
    t_grades row_max;
    t_pick   n_win;
    t_grade  r_best;
    t_label  r_lkp, r_lki, r_lkd;
    t_result dres, r_res;
    t_grade  n_best;
    logic [2:0] n_br, n_bc;

    // later entry wins only when strictly greater
    function automatic t_pick later_if_greater(t_pick a, t_pick b);
        return (b.val > a.val) ? b : a;
    endfunction

    function automatic t_pick best_of7(t_grades v);
        t_pick c [0:6];
        t_pick m01, m23, m45, m0123, m456;
        for (int j = 0; j < 7; j++) begin
            c[j].val = v[j];
            c[j].idx = 3'(j);
        end
        m01   = later_if_greater(c[0], c[1]);
        m23   = later_if_greater(c[2], c[3]);
        m45   = later_if_greater(c[4], c[5]);
        m0123 = later_if_greater(m01, m23);
        m456  = later_if_greater(m45, c[6]);
        return later_if_greater(m0123, m456);
    endfunction

    fpgt_fuzzify #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_fe (
        .i_x(s_axis_tdata[SAMPLE_WIDTH-1:0]), .o_g(ge));
    fpgt_fuzzify #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_fc (
        .i_x(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]), .o_g(gc));

    always_comb begin
        for (int i = 0; i < 7; i++)
            n_row[i] = best_of7(r_s[i]);
    end

    always_comb begin
        for (int i = 0; i < 7; i++)
            row_max[i] = r_row[i].val;
        n_win  = best_of7(row_max);
        n_br   = n_win.idx;
        n_bc   = r_row[n_win.idx].idx;
        n_best = n_win.val;
    end

    fpgt_defuzz u_dz (
        .i_nkp(line_num(r_lkp, r_best)),
        .i_nki(line_num(r_lki, r_best)),
        .i_nkd(line_num(r_lkd, r_best)),
        .o_res(dres));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[3:0], s_axis_tvalid};
        end
        if (adv) begin
            r_ge <= ge;
            r_gc <= gc;
            for (int i = 0; i < 7; i++)
                for (int j = 0; j < 7; j++)
                    r_s[i][j] <= (r_ge[j] < r_gc[i]) ? r_ge[j] : r_gc[i];
            for (int i = 0; i < 7; i++)
                r_row[i] <= n_row[i];
            r_best <= n_best;
            r_lkp <= TabKp[n_br][n_bc];
            r_lki <= TabKi[n_br][n_bc];
            r_lkd <= TabKd[n_br][n_bc];
            r_res <= dres;
        end
    end

    assign m_axis_tvalid = r_v[4];
    assign m_axis_tdata  = r_res;

endmodule
